// ===== rtl/sct_pkg.sv =====
`default_nettype none

package sct_pkg;

    // Field widths
    localparam int IN_W       = 17;   // x_in, y_in, clip offsets
    localparam int OUT_W      = 18;   // x_out, y_out
    localparam int VAL_W      = 19;   // internal signed working width
    localparam int MAG_W      = 18;   // magnitude fed to the remainder chain
    localparam int SIZE_W     = 16;   // clip width / height
    localparam int RECT_W     = 32;   // I/O rect registers
    localparam int FLAG_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int COORD_BITS_DEF = 16;

    // One restoring step per cell, one cell per magnitude bit
    localparam int REM_STEPS = MAG_W;

    // Start to done: head stage, remainder cells, two tail stages
    localparam int PIPE_LAT = REM_STEPS + 3;

    localparam logic signed [VAL_W-1:0] VAL_ONE = VAL_W'(1);

    // view_flags bit positions
    localparam int FLAG_XMIRROR = 0;
    localparam int FLAG_YMIRROR = 1;
    localparam int FLAG_XWRAP   = 2;
    localparam int FLAG_YWRAP   = 3;
    localparam int FLAG_XYSWAP  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEW_FLAGS    = 3'd0,
        REG_CLIP_X_OFFSET = 3'd1,
        REG_CLIP_Y_OFFSET = 3'd2,
        REG_CLIP_WIDTH    = 3'd3,
        REG_CLIP_HEIGHT   = 3'd4,
        REG_IO_RECT_MIN   = 3'd5,
        REG_IO_RECT_END   = 3'd6
    } sct_reg_t;

    typedef enum logic {
        CMD_FORWARD = 1'b0,
        CMD_REVERSE = 1'b1
    } sct_cmd_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [FLAG_W-1:0]        flags;
        logic signed [IN_W-1:0]   x_off;
        logic signed [IN_W-1:0]   y_off;
        logic [SIZE_W-1:0]        width;
        logic [SIZE_W-1:0]        height;
        logic [RECT_W-1:0]        io_min;
        logic [RECT_W-1:0]        io_end;
    } sct_cfg_t;

    // One beat travelling down the cell row
    typedef struct packed {
        logic                     valid;
        sct_cmd_t                 cmd;
        logic                     neg_x;
        logic                     neg_y;
        logic signed [VAL_W-1:0]  vx;
        logic signed [VAL_W-1:0]  vy;
        logic [MAG_W-1:0]         rx;
        logic [MAG_W-1:0]         ry;
    } sct_item_t;

endpackage

`default_nettype wire

// ===== rtl/surface_coordinate_translator.sv =====
`default_nettype none

// Channel   | Signals                              | Direction | Handshake
// ----------+--------------------------------------+-----------+--------------------------
// command   | start, command, x_in, y_in           | in        | beat taken at start && !busy
// result    | done, ok, x_out, y_out               | out       | one-cycle strobe on done
// config    | cfg_write, cfg_index, cfg_data       | in        | written when cfg_write high
//
// From start to done a beat passes one head stage, one restoring remainder
// cell per magnitude bit (18 cells) and two tail stages.
// One beat is taken every cycle; busy is always low.
// Reset (rst_n, asynchronous) clears the valid bits and loads register defaults.
// The receiver cannot stall: each result shows for exactly one cycle.

module surface_coordinate_translator
    import sct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         command,
    input  wire logic signed [IN_W-1:0]       x_in,
    input  wire logic signed [IN_W-1:0]       y_in,
    output logic                              done,
    output logic                              ok,
    output logic signed [OUT_W-1:0]           x_out,
    output logic signed [OUT_W-1:0]           y_out,
    input  wire logic                         cfg_write,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    sct_cfg_t   cfg_reg, cfg_next;
    logic       accept;
    sct_item_t  chain [REM_STEPS+1];

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (sct_reg_t'(cfg_index))
                REG_VIEW_FLAGS:    cfg_next.flags  = cfg_data[FLAG_W-1:0];
                REG_CLIP_X_OFFSET: cfg_next.x_off  = signed'(cfg_data[IN_W-1:0]);
                REG_CLIP_Y_OFFSET: cfg_next.y_off  = signed'(cfg_data[IN_W-1:0]);
                REG_CLIP_WIDTH:    cfg_next.width  = cfg_data[SIZE_W-1:0];
                REG_CLIP_HEIGHT:   cfg_next.height = cfg_data[SIZE_W-1:0];
                REG_IO_RECT_MIN:   cfg_next.io_min = cfg_data[RECT_W-1:0];
                REG_IO_RECT_END:   cfg_next.io_end = cfg_data[RECT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flags  <= '0;
            cfg_reg.x_off  <= '0;
            cfg_reg.y_off  <= '0;
            cfg_reg.width  <= '1;
            cfg_reg.height <= '1;
            cfg_reg.io_min <= '0;
            cfg_reg.io_end <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Mirror and sign/magnitude split for forward beats, x/y swap for reverse beats
    sct_head u_head (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (command),
        .x_in    (x_in),
        .y_in    (y_in),
        .cfg     (cfg_reg),
        .item    (chain[0])
    );

    // Remainder cells, most significant shift first
    for (genvar i = 0; i < REM_STEPS; i++)
    begin : g_cell
        sct_cell #(
            .SHIFT (REM_STEPS - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .div_x    (cfg_reg.width),
            .div_y    (cfg_reg.height),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    // Wrap, offset, bounds check, swap or unoffset and mirror, and result registers
    sct_tail #(
        .COORD_BITS (COORD_BITS)
    ) u_tail (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (chain[REM_STEPS]),
        .done  (done),
        .ok    (ok),
        .x_out (x_out),
        .y_out (y_out)
    );

endmodule

`default_nettype wire

// ===== rtl/sct_head.sv =====
`default_nettype none

module sct_head
    import sct_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic                    command,
    input  wire logic signed [IN_W-1:0]  x_in,
    input  wire logic signed [IN_W-1:0]  y_in,
    input  wire sct_cfg_t                cfg,
    output sct_item_t                    item
);

    logic                     valid_reg;
    sct_item_t                data_reg;
    sct_item_t                data_next;

    logic signed [VAL_W-1:0]  xs, ys, wx, hy;
    logic signed [VAL_W-1:0]  vx, vy, nvx, nvy;

    // Widen inputs and clip sizes
    assign xs = {{(VAL_W-IN_W){x_in[IN_W-1]}}, x_in};
    assign ys = {{(VAL_W-IN_W){y_in[IN_W-1]}}, y_in};
    assign wx = signed'({{(VAL_W-SIZE_W){1'b0}}, cfg.width});
    assign hy = signed'({{(VAL_W-SIZE_W){1'b0}}, cfg.height});

    // Mirror, and its negation in parallel so the magnitude needs no second add
    always_comb
    begin
        if (cfg.flags[FLAG_XMIRROR])
        begin
            vx  = wx - VAL_ONE - xs;
            nvx = xs + VAL_ONE - wx;
        end
        else
        begin
            vx  = xs;
            nvx = -xs;
        end
        if (cfg.flags[FLAG_YMIRROR])
        begin
            vy  = hy - VAL_ONE - ys;
            nvy = ys + VAL_ONE - hy;
        end
        else
        begin
            vy  = ys;
            nvy = -ys;
        end
    end

    // Forward beats carry sign and magnitude; reverse beats are swapped here when FLAG_XYSWAP is set
    always_comb
    begin
        data_next       = '0;
        data_next.valid = accept;
        data_next.cmd   = sct_cmd_t'(command);
        if (sct_cmd_t'(command) == CMD_FORWARD)
        begin
            data_next.vx    = vx;
            data_next.vy    = vy;
            data_next.neg_x = vx[VAL_W-1];
            data_next.neg_y = vy[VAL_W-1];
            data_next.rx    = vx[VAL_W-1] ? nvx[MAG_W-1:0] : vx[MAG_W-1:0];
            data_next.ry    = vy[VAL_W-1] ? nvy[MAG_W-1:0] : vy[MAG_W-1:0];
        end
        else
        begin
            data_next.vx = cfg.flags[FLAG_XYSWAP] ? ys : xs;
            data_next.vy = cfg.flags[FLAG_XYSWAP] ? xs : ys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        item       = data_reg;
        item.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/sct_cell.sv =====
`default_nettype none

// One restoring remainder step for both lanes: subtract divisor << SHIFT if it fits
module sct_cell
    import sct_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [SIZE_W-1:0]   div_x,
    input  wire logic [SIZE_W-1:0]   div_y,
    input  wire sct_item_t           item_in,
    output sct_item_t                item_out
);

    localparam int CW = SIZE_W + REM_STEPS;

    logic                 valid_reg;
    sct_item_t            data_reg;
    sct_item_t            data_next;

    logic [CW-1:0]        dsh_x, dsh_y;
    logic [CW-1:0]        rem_x, rem_y;

    assign dsh_x = CW'(div_x) << SHIFT;
    assign dsh_y = CW'(div_y) << SHIFT;
    assign rem_x = CW'(item_in.rx);
    assign rem_y = CW'(item_in.ry);

    // Conditional subtract per lane
    always_comb
    begin
        data_next = item_in;
        if (rem_x >= dsh_x)
        begin
            data_next.rx = item_in.rx - dsh_x[MAG_W-1:0];
        end
        if (rem_y >= dsh_y)
        begin
            data_next.ry = item_in.ry - dsh_y[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        item_out       = data_reg;
        item_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/sct_tail.sv =====
`default_nettype none

module sct_tail
    import sct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sct_cfg_t                 cfg,
    input  wire sct_item_t                item,
    output logic                          done,
    output logic                          ok,
    output logic signed [OUT_W-1:0]       x_out,
    output logic signed [OUT_W-1:0]       y_out
);

    localparam logic [RECT_W-1:0] CMASK = RECT_W'((64'd1 << COORD_BITS) - 64'd1);

    // Stage A registers
    logic                     a_valid_reg;
    sct_cmd_t                 a_cmd_reg, a_cmd_next;
    logic signed [VAL_W-1:0]  a_px_reg, a_px_next;
    logic signed [VAL_W-1:0]  a_py_reg, a_py_next;

    // Output registers
    logic                     done_reg;
    logic                     ok_reg, ok_next;
    logic signed [OUT_W-1:0]  x_reg, x_next;
    logic signed [OUT_W-1:0]  y_reg, y_next;

    logic [SIZE_W-1:0]        fx, fy;
    logic signed [VAL_W-1:0]  wrx, wry, offx, offy, wx, hy, qx, qy;
    logic [RECT_W-1:0]        xmin, ymin, xend, yend, pxu, pyu;

    assign offx = {{(VAL_W-IN_W){cfg.x_off[IN_W-1]}}, cfg.x_off};
    assign offy = {{(VAL_W-IN_W){cfg.y_off[IN_W-1]}}, cfg.y_off};
    assign wx   = signed'({{(VAL_W-SIZE_W){1'b0}}, cfg.width});
    assign hy   = signed'({{(VAL_W-SIZE_W){1'b0}}, cfg.height});

    // Stage A: floor correction of the remainder, wrap select, add clip offset to forward beats
    always_comb
    begin
        fx = (item.neg_x && item.rx != '0)
             ? SIZE_W'({{(MAG_W-SIZE_W){1'b0}}, cfg.width} - item.rx)
             : item.rx[SIZE_W-1:0];
        fy = (item.neg_y && item.ry != '0)
             ? SIZE_W'({{(MAG_W-SIZE_W){1'b0}}, cfg.height} - item.ry)
             : item.ry[SIZE_W-1:0];

        wrx = (cfg.flags[FLAG_XWRAP] && cfg.width != '0)
              ? signed'({{(VAL_W-SIZE_W){1'b0}}, fx}) : item.vx;
        wry = (cfg.flags[FLAG_YWRAP] && cfg.height != '0)
              ? signed'({{(VAL_W-SIZE_W){1'b0}}, fy}) : item.vy;

        a_cmd_next = item.cmd;
        if (item.cmd == CMD_FORWARD)
        begin
            a_px_next = wrx + offx;
            a_py_next = wry + offy;
        end
        else
        begin
            a_px_next = item.vx;
            a_py_next = item.vy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= item.valid;
            done_reg    <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_cmd_reg <= a_cmd_next;
        a_px_reg  <= a_px_next;
        a_py_reg  <= a_py_next;
        ok_reg    <= ok_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
    end

    // I/O rect bounds
    assign xmin = cfg.io_min & CMASK;
    assign ymin = (cfg.io_min >> COORD_BITS) & CMASK;
    assign xend = cfg.io_end & CMASK;
    assign yend = (cfg.io_end >> COORD_BITS) & CMASK;
    assign pxu  = RECT_W'(a_px_reg[VAL_W-2:0]);
    assign pyu  = RECT_W'(a_py_reg[VAL_W-2:0]);

    // Stage B: bounds check, then swap (forward) or unoffset and mirror (reverse)
    always_comb
    begin
        ok_next = !a_px_reg[VAL_W-1] && !a_py_reg[VAL_W-1]
                  && pxu >= xmin && pyu >= ymin && pxu < xend && pyu < yend;

        qx = cfg.flags[FLAG_XMIRROR] ? wx - VAL_ONE - a_px_reg + offx : a_px_reg - offx;
        qy = cfg.flags[FLAG_YMIRROR] ? hy - VAL_ONE - a_py_reg + offy : a_py_reg - offy;

        if (!ok_next)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (a_cmd_reg == CMD_REVERSE)
        begin
            x_next = qx[OUT_W-1:0];
            y_next = qy[OUT_W-1:0];
        end
        else if (cfg.flags[FLAG_XYSWAP])
        begin
            x_next = a_py_reg[OUT_W-1:0];
            y_next = a_px_reg[OUT_W-1:0];
        end
        else
        begin
            x_next = a_px_reg[OUT_W-1:0];
            y_next = a_py_reg[OUT_W-1:0];
        end
    end

    assign done  = done_reg;
    assign ok    = ok_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

`default_nettype wire

// ===== rtl/sct_checker.sv =====
`default_nettype none

module sct_checker
    import sct_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic                         done,
    input  wire logic                         ok,
    input  wire logic signed [OUT_W-1:0]      x_out,
    input  wire logic signed [OUT_W-1:0]      y_out
);

    // Every accepted beat gives a result after the fixed latency
    a_beat_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("accepted beat produced no result");

    // No result without an accepted beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a matching beat");

    // A failed bounds check returns zero coordinates
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (x_out == '0 && y_out == '0))
        else $error("nonzero coordinates on failed check");

endmodule

bind surface_coordinate_translator sct_checker u_sct_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ok    (ok),
    .x_out (x_out),
    .y_out (y_out)
);

`default_nettype wire
